// ----- rtl/core/amo_alu_pkg.sv -----
// ----------------------------------------------------------------------------
// amo_alu_pkg
// Shared types and codes for the atomic memory operation ALU.
// ----------------------------------------------------------------------------
package amo_alu_pkg;

	localparam int unsigned DataW = 64;

	typedef enum logic [3:0] {
		MODE_LOAD  = 4'd0,
		MODE_STORE = 4'd1,
		MODE_ADD   = 4'd2,
		MODE_AND   = 4'd3,
		MODE_OR    = 4'd4,
		MODE_XOR   = 4'd5,
		MODE_SMIN  = 4'd6,
		MODE_SMAX  = 4'd7,
		MODE_UMIN  = 4'd8,
		MODE_UMAX  = 4'd9,
		MODE_SWAP  = 4'd10,
		MODE_CAS   = 4'd11,
		MODE_FENCE = 4'd12
	} mode_e;

	typedef enum logic [2:0] {
		ORD_RELAXED = 3'd0,
		ORD_ACQUIRE = 3'd1,
		ORD_RELEASE = 3'd2,
		ORD_ACQ_REL = 3'd3,
		ORD_SEQ_CST = 3'd4
	} order_e;

	typedef enum logic [2:0] {
		SIZE_1B  = 3'd0,
		SIZE_2B  = 3'd1,
		SIZE_4B  = 3'd2,
		SIZE_8B  = 3'd3,
		SIZE_16B = 3'd4
	} size_e;

	// decoded control for one item
	typedef struct packed {
		logic             illegal;
		mode_e            op;
		logic             wide;     // 16-byte access
		logic             keep_old; // fetch-op writes the destination register
		logic [DataW-1:0] mask;     // bytes covered by the access
		logic [DataW-1:0] sign;     // sign bit of the access size
	} dec_t;

	typedef struct packed {
		logic [DataW-1:0] old_low;
		logic [DataW-1:0] old_high;
		logic [DataW-1:0] new_low;
		logic [DataW-1:0] new_high;
		logic             mem_write;
		logic             reg_write;
		logic             status;
	} res_t;

endpackage

// ----- rtl/core/amo_alu_decode.sv -----
// ----------------------------------------------------------------------------
// amo_alu_decode
// Legality check and size decode for one atomic instruction.
// ----------------------------------------------------------------------------
module amo_alu_decode (
	input  logic [3:0]         mode,
	input  logic               discard_old,
	input  logic [2:0]         size_code,
	input  logic [2:0]         order,
	output amo_alu_pkg::dec_t  dec
);
	import amo_alu_pkg::*;

	logic order_ok;
	logic is_fop;
	logic bad_size;

	always_comb begin
		case (mode)
			MODE_LOAD:  order_ok = (order inside {ORD_RELAXED, ORD_ACQUIRE, ORD_SEQ_CST});
			MODE_STORE: order_ok = (order inside {ORD_RELAXED, ORD_RELEASE, ORD_SEQ_CST});
			MODE_FENCE: order_ok = (order inside {[ORD_ACQUIRE:ORD_SEQ_CST]});
			default:    order_ok = (order inside {[ORD_RELAXED:ORD_SEQ_CST]});
		endcase
	end

	assign is_fop   = (mode inside {[MODE_ADD:MODE_UMAX]});
	assign bad_size = (mode != MODE_FENCE) && (size_code > SIZE_16B);

	always_comb begin
		dec          = '0;
		dec.op       = mode_e'(mode);
		dec.illegal  = (mode > MODE_FENCE) || !order_ok || bad_size
		             || (is_fop && (size_code == SIZE_16B));
		dec.wide     = (size_code == SIZE_16B);
		dec.keep_old = !discard_old;
		case (size_code)
			SIZE_1B: begin
				dec.mask = {{(DataW-8){1'b0}}, 8'hff};
				dec.sign = {{(DataW-8){1'b0}}, 8'h80};
			end
			SIZE_2B: begin
				dec.mask = {{(DataW-16){1'b0}}, 16'hffff};
				dec.sign = {{(DataW-16){1'b0}}, 16'h8000};
			end
			SIZE_4B: begin
				dec.mask = {{(DataW-32){1'b0}}, 32'hffff_ffff};
				dec.sign = {{(DataW-32){1'b0}}, 32'h8000_0000};
			end
			default: begin
				dec.mask = '1;
				dec.sign = {1'b1, {(DataW-1){1'b0}}};
			end
		endcase
	end

endmodule

// ----- rtl/core/amo_alu_exec.sv -----
// ----------------------------------------------------------------------------
// amo_alu_exec
// Data path: masking, fetch-op arithmetic, compare and result selection.
// ----------------------------------------------------------------------------
module amo_alu_exec (
	input  amo_alu_pkg::dec_t  dec,
	input  logic [63:0]        mem_low,
	input  logic [63:0]        mem_high,
	input  logic [63:0]        operand_low,
	input  logic [63:0]        operand_high,
	input  logic [63:0]        compare_low,
	input  logic [63:0]        compare_high,
	output amo_alu_pkg::res_t  res
);
	import amo_alu_pkg::*;

	logic [DataW-1:0] mlo, mhi, olo, ohi, clo, chi;
	logic [DataW-1:0] sum, fop_val, fop_old;
	logic             lt_s, lt_u, cas_hit;

	assign mlo = mem_low & dec.mask;
	assign olo = operand_low & dec.mask;
	assign clo = compare_low & dec.mask;
	assign mhi = dec.wide ? mem_high : '0;
	assign ohi = dec.wide ? operand_high : '0;
	assign chi = dec.wide ? compare_high : '0;

	assign sum     = (mlo + olo) & dec.mask;
	assign lt_s    = (mlo ^ dec.sign) < (olo ^ dec.sign);
	assign lt_u    = mlo < olo;
	assign cas_hit = (mlo == clo) && (mhi == chi);

	always_comb begin
		case (dec.op)
			MODE_ADD:  fop_val = sum;
			MODE_AND:  fop_val = mlo & olo;
			MODE_OR:   fop_val = mlo | olo;
			MODE_XOR:  fop_val = mlo ^ olo;
			MODE_SMIN: fop_val = lt_s ? mlo : olo;
			MODE_SMAX: fop_val = lt_s ? olo : mlo;
			MODE_UMIN: fop_val = lt_u ? mlo : olo;
			default:   fop_val = lt_u ? olo : mlo;
		endcase
	end

	// signed min/max return the old value sign-extended
	assign fop_old = ((dec.op inside {MODE_SMIN, MODE_SMAX}) && |(mlo & dec.sign))
	               ? (mlo | ~dec.mask) : mlo;

	always_comb begin
		res = '0;
		if (dec.illegal) begin
			res.status = 1'b1;
		end else begin
			case (dec.op)
				MODE_FENCE: begin
					res = '0;
				end
				MODE_LOAD: begin
					res.old_low   = mlo;
					res.old_high  = mhi;
					res.reg_write = 1'b1;
				end
				MODE_STORE: begin
					res.new_low   = olo;
					res.new_high  = ohi;
					res.mem_write = 1'b1;
				end
				MODE_SWAP: begin
					res.old_low   = mlo;
					res.old_high  = mhi;
					res.new_low   = olo;
					res.new_high  = ohi;
					res.mem_write = 1'b1;
					res.reg_write = 1'b1;
				end
				MODE_CAS: begin
					res.old_low   = mlo;
					res.old_high  = mhi;
					res.reg_write = 1'b1;
					if (cas_hit) begin
						res.new_low   = olo;
						res.new_high  = ohi;
						res.mem_write = 1'b1;
					end
				end
				default: begin
					res.old_low   = fop_old;
					res.new_low   = fop_val;
					res.mem_write = 1'b1;
					res.reg_write = dec.keep_old;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/atomic_memory_op_alu_core.sv -----
// ----------------------------------------------------------------------------
// atomic_memory_op_alu_core
// Atomic memory operation ALU: load, store, fetch-op, swap, CAS and fence.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one instruction item: the control fields in tuser, the
//   current memory contents, operand and CAS expected value in tdata.
//   m_axis returns one result item per instruction: old value for the
//   destination register and new value for memory in tdata, the write
//   enables and status in tuser.
//   Two register stages: the input register (_s1) and the result register
//   (_s2). Decode and arithmetic sit between them, so an accepted item
//   passes through _s1 and then _s2, whose result is shown on m_axis and
//   is taken while m_axis_tready is high.
//   Throughput is one item per cycle while m_axis does not stall; an empty
//   input stage takes an item while an earlier result still waits on m_axis.
//   When m_axis stalls the result holds; s_axis_tready drops only once
//   both stages are full, and the input stage keeps its item.
//   Reset (arst_n low) empties both stages at once; no results are lost
//   other than those in flight, and the block is ready again after reset.
//   Illegal instructions return status 1 with every other field zero.
// ----------------------------------------------------------------------------
module atomic_memory_op_alu_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [63:0] mem_low, [127:64] mem_high, [191:128] operand_low,
	// [255:192] operand_high, [319:256] compare_low, [383:320] compare_high
	input  logic [383:0] s_axis_tdata,
	// [3:0] mode, [4] discard_old, [7:5] size_code, [10:8] order, rest zero
	input  logic [15:0]  s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [63:0] old_low, [127:64] old_high, [191:128] new_low, [255:192] new_high
	output logic [255:0] m_axis_tdata,
	// [0] mem_write, [1] reg_write, [2] status, rest zero
	output logic [7:0]   m_axis_tuser
);
	import amo_alu_pkg::*;

	// input stage
	logic         valid_s1;
	logic [383:0] data_s1;
	logic [10:0]  user_s1;

	// result stage
	logic         valid_s2;
	res_t         res_s2;

	logic advance;
	dec_t dec;
	res_t res;

	// result register frees up when empty or when it is taken this cycle
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata;
			user_s1 <= s_axis_tuser[10:0];
		end
	end

	amo_alu_decode u_decode (
		.mode        (user_s1[3:0]),
		.discard_old (user_s1[4]),
		.size_code   (user_s1[7:5]),
		.order       (user_s1[10:8]),
		.dec         (dec)
	);

	amo_alu_exec u_exec (
		.dec          (dec),
		.mem_low      (data_s1[63:0]),
		.mem_high     (data_s1[127:64]),
		.operand_low  (data_s1[191:128]),
		.operand_high (data_s1[255:192]),
		.compare_low  (data_s1[319:256]),
		.compare_high (data_s1[383:320]),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.new_high, res_s2.new_low, res_s2.old_high, res_s2.old_low};
	assign m_axis_tuser  = {5'b0, res_s2.status, res_s2.reg_write, res_s2.mem_write};

endmodule

// ----- rtl/core/amo_alu_checker.sv -----
// ----------------------------------------------------------------------------
// amo_alu_checker
// Port-level checks for the atomic memory operation ALU.
// ----------------------------------------------------------------------------
module amo_alu_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [255:0] m_axis_tdata,
	input logic [7:0]   m_axis_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// input back-pressure only comes from a stalled, full output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output stall");

	// illegal instruction: everything else zero
	a_illegal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |->
			m_axis_tdata == 256'd0 && m_axis_tuser[1:0] == 2'b00)
		else $error("illegal result carries data");

	// no memory write: new value zero (load, failed cas, fence, illegal)
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[255:128] == 128'd0)
		else $error("new value without memory write");

	// neither write: fence or illegal, old value zero
	a_fence_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == 2'b00 |-> m_axis_tdata[127:0] == 128'd0)
		else $error("old value without register write");

endmodule

bind atomic_memory_op_alu_core amo_alu_checker u_amo_alu_checker (.*);
